// ----- sv/bmpx_pkg.sv -----
// bmpx_pkg: shared types and constants for the bitmap lsb message extractor
// used by bmpx_pitch and bmp_lsb_message_extractor; no dependencies
`default_nettype none
package bmpx_pkg;

   // file walk phase
   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PIXELS,
      PH_DONE
   } phase_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_DATA,
      ST_BAD_FILE,
      ST_BAD_LENGTH,
      ST_EXHAUSTED
   } status_type;

   localparam int UsableW = 33;   // width * 3 for a positive 31-bit width
   localparam int PitchW  = 45;   // padded row length in bytes

   // header fields needed for the row geometry
   typedef struct packed {
      logic [31:0] width;
      logic [15:0] bpp;
   } geom_type;

   // row geometry returned to the walker
   typedef struct packed {
      logic [UsableW-1:0] usable;
      logic [PitchW-1:0]  pitch;
   } row_type;

   localparam logic [15:0] TypeMagic   = 16'h4D42;
   localparam logic [31:0] MinOffset   = 32'd30;
   localparam logic [5:0]  LenBits     = 6'd32;
   localparam logic [30:0] MaxLenReset = 31'd1000000;

   // header byte positions, little endian fields
   localparam logic [31:0] PosTypeLo   = 32'd0;
   localparam logic [31:0] PosTypeHi   = 32'd1;
   localparam logic [31:0] PosOffsetLo = 32'd10;
   localparam logic [31:0] PosOffsetHi = 32'd13;
   localparam logic [31:0] PosWidthLo  = 32'd18;
   localparam logic [31:0] PosWidthHi  = 32'd21;
   localparam logic [31:0] PosHeightLo = 32'd22;
   localparam logic [31:0] PosHeightHi = 32'd25;
   localparam logic [31:0] PosBppLo    = 32'd28;
   localparam logic [31:0] PosBppHi    = 32'd29;

endpackage
`default_nettype wire

// ----- sv/bmpx_pitch.sv -----
// bmpx_pitch: usable bytes per row and padded row pitch from the header fields
// two register stages around the bits-per-pixel multiply; uses bmpx_pkg
`default_nettype none
module bmpx_pitch (
   input  logic               clock,
   input  bmpx_pkg::geom_type geom,
   output bmpx_pkg::row_type  row
);

   localparam logic [47:0] RoundAdd = 48'd31;   // round up to a 32-bit word

   logic [30:0]                    width_pos;
   logic [bmpx_pkg::UsableW-1:0]   usable_ff, usable_in;
   logic [46:0]                    prod_ff, prod_in;
   logic [47:0]                    round_sum;
   logic [bmpx_pkg::PitchW-1:0]    pitch_raw;
   logic [bmpx_pkg::PitchW-1:0]    usable_wide;
   logic [bmpx_pkg::PitchW-1:0]    pitch_ff, pitch_in;

   // negative width leaves no usable bytes
   assign width_pos = geom.width[31] ? 31'd0 : geom.width[30:0];
   assign usable_in = {2'b00, width_pos} + {1'b0, width_pos, 1'b0};
   assign prod_in   = 47'(geom.bpp) * 47'(width_pos);

   assign round_sum   = {1'b0, prod_ff} + RoundAdd;
   assign pitch_raw   = {round_sum[47:5], 2'b00};
   assign usable_wide = {{(bmpx_pkg::PitchW - bmpx_pkg::UsableW){1'b0}}, usable_ff};
   // a short pitch is raised so used bytes of rows never overlap
   assign pitch_in    = (pitch_raw < usable_wide) ? usable_wide : pitch_raw;

   always_ff @(posedge clock) begin
      usable_ff <= usable_in;
      prod_ff   <= prod_in;
      pitch_ff  <= pitch_in;
   end

   assign row.usable = usable_ff;
   assign row.pitch  = pitch_ff;

endmodule
`default_nettype wire

// ----- sv/bmp_lsb_message_extractor.sv -----
// bmp_lsb_message_extractor: top level, recovers an lsb-hidden message from a bitmap
// uses bmpx_pkg and bmpx_pitch
//
// usage:
//  - req channel: one file byte per item with an end_of_file flag on the final byte.
//    items are accepted on req_valid high and req_stall low.
//  - rsp channel: at most one item per file byte: a message byte, last_byte on the
//    final item of a file, and a status (data, bad file, bad length, exhausted).
//    taken on rsp_valid high and rsp_stall low.
//  - csr channel: writes the maximum message length (31 bits); csr_ready is always
//    high. write only while the block is idle.
//  - an accepted item is held in the input register; its result is written to the
//    output register when the item leaves it. throughput is one byte per cycle while
//    rsp is not stalled, set by the single register pair around the per-byte update logic.
//  - the row pitch comes from the bits-per-pixel field through the product and pitch
//    registers of bmpx_pitch, and settles before it is first needed on the third pixel byte.
//  - reset clears the walk state and sets the maximum length to 1000000.
//  - while rsp is stalled with a result held, one more byte is taken into the
//    input register; then req_stall rises until the output register drains.
`default_nettype none
module bmp_lsb_message_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_file_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_message_byte,
   output logic        rsp_last_byte,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_max_message_length
);

   localparam int PW = bmpx_pkg::PitchW;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eof_ff;
   logic       req_accept;
   logic       fire;

   // walk state
   bmpx_pkg::phase_type phase_ff, phase_in, phase_core;
   logic [31:0]   pos_ff, pos_in;
   logic [PW-1:0] byte_row_ff, byte_row_in;
   logic [31:0]   rows_ff, rows_in;
   logic [5:0]    len_seen_ff, len_seen_in;
   logic [31:0]   len_ff, len_in;
   logic [7:0]    chr_ff, chr_in;
   logic [2:0]    chr_idx_ff, chr_idx_in;
   logic [31:0]   chars_ff, chars_in;
   logic [30:0]   max_len_ff;

   // header fields
   logic [7:0]  first_ff, first_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [15:0] bpp_ff, bpp_in;

   bmpx_pkg::geom_type geom;
   bmpx_pkg::row_type  row;

   // decode helpers
   logic [1:0]    lane_ofs, lane_wid, lane_hgt;
   logic          lane_bpp;
   logic [31:0]   hgt_raw, hgt_mag;
   logic          type_bad, ofs_bad, pix_start, geom_ok, pix_active;
   logic [PW-1:0] usable_wide, byte_next;
   logic          in_use, last_use, last_row, exhausted, row_wrap;
   logic [31:0]   len_full;
   logic          len_last, len_bad;
   logic [7:0]    chr_val;
   logic [31:0]   chars_next;
   logic          msg_done;

   // per-byte result before and after the end-of-file rules
   logic                 core_valid, core_last;
   logic [7:0]           core_msg;
   bmpx_pkg::status_type core_status;
   logic                 res_valid, res_last;
   logic [7:0]           res_msg;
   bmpx_pkg::status_type res_status;

   // output register
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_byte_ff;
   logic                 rsp_last_ff;
   bmpx_pkg::status_type rsp_status_ff;

   // ---------------- handshakes ----------------
   assign fire        = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !fire;
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         in_byte_ff <= req_file_byte;
         in_eof_ff  <= req_end_of_file;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= bmpx_pkg::MaxLenReset;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_max_message_length;
      end
   end

   // ---------------- row geometry ----------------
   assign geom.width = width_ff;
   assign geom.bpp   = bpp_ff;

   bmpx_pitch u_pitch (
      .clock (clock),
      .geom  (geom),
      .row   (row)
   );

   // ---------------- decode ----------------
   assign lane_ofs = pos_ff[1:0] - bmpx_pkg::PosOffsetLo[1:0];
   assign lane_wid = pos_ff[1:0] - bmpx_pkg::PosWidthLo[1:0];
   assign lane_hgt = pos_ff[1:0] - bmpx_pkg::PosHeightLo[1:0];
   assign lane_bpp = pos_ff[0] ^ bmpx_pkg::PosBppLo[0];

   // height is kept as a magnitude; the most negative value becomes 2^31
   assign hgt_raw = {in_byte_ff, height_ff[23:0]};
   assign hgt_mag = hgt_raw[31] ? (~hgt_raw + 32'd1) : hgt_raw;

   assign type_bad  = (pos_ff == bmpx_pkg::PosTypeHi) &&
                      ({in_byte_ff, first_ff} != bmpx_pkg::TypeMagic);
   assign ofs_bad   = (pos_ff == bmpx_pkg::PosOffsetHi) &&
                      ({in_byte_ff, offset_ff[23:0]} < bmpx_pkg::MinOffset);
   assign pix_start = (pos_ff >= bmpx_pkg::MinOffset) && (pos_ff == offset_ff);
   assign geom_ok   = (row.usable != '0) && (height_ff != 32'd0);

   assign pix_active = fire && ((phase_ff == bmpx_pkg::PH_PIXELS) ||
                                ((phase_ff == bmpx_pkg::PH_HEADER) && pix_start && geom_ok));

   assign usable_wide = {{(PW - bmpx_pkg::UsableW){1'b0}}, row.usable};
   assign byte_next   = byte_row_ff + {{(PW - 1){1'b0}}, 1'b1};
   assign in_use      = byte_row_ff < usable_wide;
   assign last_use    = byte_next == usable_wide;
   assign last_row    = ({1'b0, rows_ff} + 33'd1) >= {1'b0, height_ff};
   assign exhausted   = in_use && last_use && last_row;
   // pitch is at least 3, and is only settled from the third pixel byte on
   assign row_wrap    = (byte_row_ff >= 45'd2) && (byte_next >= row.pitch);

   assign len_full = len_ff | (32'(in_byte_ff[0]) << len_seen_ff[4:0]);
   assign len_last = len_seen_ff == (bmpx_pkg::LenBits - 6'd1);
   assign len_bad  = (len_full == 32'd0) || len_full[31] || (len_full[30:0] > max_len_ff);

   assign chr_val    = chr_ff | (8'(in_byte_ff[0]) << chr_idx_ff);
   assign chars_next = chars_ff + 32'd1;
   assign msg_done   = chars_next == len_ff;

   // ---------------- per-byte datapath ----------------
   always_comb begin
      first_in    = first_ff;
      offset_in   = offset_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      bpp_in      = bpp_ff;
      pos_in      = pos_ff;
      byte_row_in = byte_row_ff;
      rows_in     = rows_ff;
      len_seen_in = len_seen_ff;
      len_in      = len_ff;
      chr_in      = chr_ff;
      chr_idx_in  = chr_idx_ff;
      chars_in    = chars_ff;
      core_valid  = 1'b0;
      core_last   = 1'b0;
      core_msg    = 8'd0;
      core_status = bmpx_pkg::ST_DATA;

      if (fire && (phase_ff == bmpx_pkg::PH_HEADER)) begin
         pos_in = pos_ff + 32'd1;
         case (pos_ff) inside
            bmpx_pkg::PosTypeLo: begin
               first_in = in_byte_ff;
            end
            [bmpx_pkg::PosOffsetLo : bmpx_pkg::PosOffsetHi]: begin
               offset_in[8*lane_ofs +: 8] = in_byte_ff;
            end
            [bmpx_pkg::PosWidthLo : bmpx_pkg::PosWidthHi]: begin
               width_in[8*lane_wid +: 8] = in_byte_ff;
            end
            bmpx_pkg::PosHeightHi: begin
               height_in = hgt_mag;
            end
            [bmpx_pkg::PosHeightLo : bmpx_pkg::PosHeightHi]: begin
               height_in[8*lane_hgt +: 8] = in_byte_ff;
            end
            [bmpx_pkg::PosBppLo : bmpx_pkg::PosBppHi]: begin
               bpp_in[8*lane_bpp +: 8] = in_byte_ff;
            end
            default: ;
         endcase
         if (type_bad || ofs_bad) begin
            core_valid  = 1'b1;
            core_last   = 1'b1;
            core_status = bmpx_pkg::ST_BAD_FILE;
         end else if (pix_start && !geom_ok) begin
            core_valid  = 1'b1;
            core_last   = 1'b1;
            core_status = bmpx_pkg::ST_EXHAUSTED;
         end
      end

      if (pix_active) begin
         if (in_use) begin
            if (!len_seen_ff[5]) begin
               // still gathering the 32-bit length
               len_in      = len_full;
               len_seen_in = len_seen_ff + 6'd1;
               if (len_last && len_bad) begin
                  core_valid  = 1'b1;
                  core_last   = 1'b1;
                  core_status = bmpx_pkg::ST_BAD_LENGTH;
               end else if (exhausted) begin
                  core_valid  = 1'b1;
                  core_last   = 1'b1;
                  core_status = bmpx_pkg::ST_EXHAUSTED;
               end
            end else begin
               chr_idx_in = chr_idx_ff + 3'd1;
               if (chr_idx_ff == 3'd7) begin
                  chr_in     = 8'd0;
                  chars_in   = chars_next;
                  core_valid = 1'b1;
                  core_msg   = chr_val;
                  if (msg_done) begin
                     core_last = 1'b1;
                  end else if (exhausted) begin
                     core_last   = 1'b1;
                     core_status = bmpx_pkg::ST_EXHAUSTED;
                  end
               end else begin
                  chr_in = chr_val;
                  if (exhausted) begin
                     core_valid  = 1'b1;
                     core_last   = 1'b1;
                     core_msg    = chr_val;
                     core_status = bmpx_pkg::ST_EXHAUSTED;
                  end
               end
            end
         end
         if (row_wrap) begin
            byte_row_in = '0;
            rows_in     = rows_ff + 32'd1;
         end else begin
            byte_row_in = byte_next;
         end
      end
   end

   // ---------------- phase next state ----------------
   always_comb begin
      phase_core = phase_ff;
      if (fire) begin
         unique case (phase_ff)
            bmpx_pkg::PH_HEADER: begin
               if (core_valid && core_last) begin
                  phase_core = bmpx_pkg::PH_DONE;
               end else if (pix_start) begin
                  phase_core = bmpx_pkg::PH_PIXELS;
               end
            end
            bmpx_pkg::PH_PIXELS: begin
               if (core_valid && core_last) begin
                  phase_core = bmpx_pkg::PH_DONE;
               end
            end
            bmpx_pkg::PH_DONE: begin
               phase_core = bmpx_pkg::PH_DONE;
            end
            default: begin
               phase_core = bmpx_pkg::PH_HEADER;
            end
         endcase
      end
      phase_in = (fire && in_eof_ff) ? bmpx_pkg::PH_HEADER : phase_core;
   end

   // ---------------- result with end-of-file rules ----------------
   always_comb begin
      res_valid  = core_valid;
      res_last   = core_last;
      res_msg    = core_msg;
      res_status = core_status;
      if (fire && in_eof_ff) begin
         if (!core_valid && (phase_core != bmpx_pkg::PH_DONE)) begin
            res_valid = 1'b1;
            res_last  = 1'b1;
            res_msg   = 8'd0;
            if ((phase_core == bmpx_pkg::PH_HEADER) && (pos_ff < bmpx_pkg::PosBppHi)) begin
               res_status = bmpx_pkg::ST_BAD_FILE;
            end else if ((phase_core == bmpx_pkg::PH_HEADER) || !len_seen_in[5]) begin
               res_status = bmpx_pkg::ST_EXHAUSTED;
            end else begin
               res_status = bmpx_pkg::ST_EXHAUSTED;
               res_msg    = chr_in;
            end
         end else if (core_valid && !core_last) begin
            // a data byte cut off by the end of file
            res_last   = 1'b1;
            res_status = bmpx_pkg::ST_EXHAUSTED;
         end
      end
   end

   // ---------------- state registers ----------------
   always_ff @(posedge clock) begin
      if (reset || (fire && in_eof_ff)) begin
         phase_ff    <= bmpx_pkg::PH_HEADER;
         pos_ff      <= 32'd0;
         byte_row_ff <= '0;
         rows_ff     <= 32'd0;
         len_seen_ff <= 6'd0;
         len_ff      <= 32'd0;
         chr_ff      <= 8'd0;
         chr_idx_ff  <= 3'd0;
         chars_ff    <= 32'd0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         byte_row_ff <= byte_row_in;
         rows_ff     <= rows_in;
         len_seen_ff <= len_seen_in;
         len_ff      <= len_in;
         chr_ff      <= chr_in;
         chr_idx_ff  <= chr_idx_in;
         chars_ff    <= chars_in;
      end
   end

   // header fields are rewritten by every file before use
   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      offset_ff <= offset_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      bpp_ff    <= bpp_in;
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= res_valid;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire && res_valid) begin
         rsp_byte_ff   <= res_msg;
         rsp_last_ff   <= res_last;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_message_byte = rsp_byte_ff;
   assign rsp_last_byte    = rsp_last_ff;
   assign rsp_status       = rsp_status_ff;

   // ---------------- assertions ----------------
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != bmpx_pkg::ST_DATA)) |-> rsp_last_ff)
      else $error("error result without last_byte");

   a_pixels_geom: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == bmpx_pkg::PH_PIXELS) |-> ((row.usable != '0) && (height_ff != 32'd0)))
      else $error("pixel walk with empty geometry");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_eof_ff)))
      else $error("held input item lost or changed");

   a_len_count: assert property (@(posedge clock) disable iff (reset)
      len_seen_ff <= bmpx_pkg::LenBits)
      else $error("length bit count overran");

endmodule
`default_nettype wire

// ----- tb/tb_bmp_lsb_message_extractor.sv -----
`timescale 1ns / 100ps
// testbench for bmp_lsb_message_extractor: streams generated bitmap files and checks each
// recovered byte against a behavioral walk of the header and pixel rows
// depends on bmpx_pkg and the extractor rtl
module tb_bmp_lsb_message_extractor;

   typedef struct {
      bit [7:0]             msg;
      bit                   last;
      bmpx_pkg::status_type st;
   } recovered_type;

   // behavioral extractor plus queue of recovered bytes still to arrive
   class message_scoreboard;
      recovered_type       expected_chars[$];
      bit [30:0]           max_len;
      bit [63:0]           pos;
      bmpx_pkg::phase_type ph;
      bit [31:0]           offset;
      bit [31:0]           width;
      bit [63:0]           height;
      bit [15:0]           bpp;
      bit [63:0]           pitch;
      bit [63:0]           col;
      bit [63:0]           rows;
      bit [5:0]            len_bits;
      bit [31:0]           len_val;
      bit [7:0]            char_acc;
      bit [3:0]            char_idx;
      bit [31:0]           chars_done;
      bit [7:0]            type_lo;
      int                  mismatches;
      int                  live_bytes;
      int                  results_seen;

      function new();
         max_len = bmpx_pkg::MaxLenReset;
         clear_walk();
      endfunction

      function void clear_walk();
         pos = 0; ph = bmpx_pkg::PH_HEADER; offset = 0; width = 0; height = 0; bpp = 0;
         pitch = 0; col = 0; rows = 0; len_bits = 0; len_val = 0; char_acc = 0;
         char_idx = 0; chars_done = 0; type_lo = 0;
      endfunction

      function void set_limit(bit [30:0] v);
         max_len = v;
      endfunction

      function bit [63:0] usable_bytes();
         if (width == 0 || width[31]) return 0;
         return 64'(width) * 3;
      endfunction

      function void header_byte(bit [7:0] b, bit [63:0] p);
         bit [63:0] w;
         bit [63:0] pch;
         if (p == bmpx_pkg::PosTypeLo) type_lo = b;
         else if (p >= bmpx_pkg::PosOffsetLo && p <= bmpx_pkg::PosOffsetHi)
            offset |= 32'(b) << (8 * (p - bmpx_pkg::PosOffsetLo));
         else if (p >= bmpx_pkg::PosWidthLo && p <= bmpx_pkg::PosWidthHi)
            width |= 32'(b) << (8 * (p - bmpx_pkg::PosWidthLo));
         else if (p >= bmpx_pkg::PosHeightLo && p <= bmpx_pkg::PosHeightHi)
            height |= 64'(b) << (8 * (p - bmpx_pkg::PosHeightLo));
         else if (p >= bmpx_pkg::PosBppLo && p <= bmpx_pkg::PosBppHi)
            bpp |= 16'(b) << (8 * (p - bmpx_pkg::PosBppLo));
         // height is kept as a magnitude, most negative stays 2^31
         if (p == bmpx_pkg::PosHeightHi && height[31])
            height = ((~height) + 1) & 64'hFFFF_FFFF;
         if (p == bmpx_pkg::PosBppHi) begin
            w = usable_bytes() / 3;
            pch = (((64'(bpp) * w) + 64'd31) >> 5) << 2;
            if (pch < usable_bytes()) pch = usable_bytes();
            pitch = pch;
         end
      endfunction

      function bit close_with(output recovered_type r, input bit [7:0] v,
                              input bmpx_pkg::status_type s);
         r.msg = v;
         r.last = 1'b1;
         r.st = s;
         ph = bmpx_pkg::PH_DONE;
         return 1'b1;
      endfunction

      function void take_file_byte(bit [7:0] b, bit eof);
         recovered_type r;
         bit            got;
         bit [63:0]     p;
         bit [63:0]     use_n;
         bit            spent;
         bit [7:0]      val;
         p = pos;
         got = 1'b0;
         live_bytes++;
         if (ph == bmpx_pkg::PH_HEADER) begin
            header_byte(b, p);
            if (p == bmpx_pkg::PosTypeHi && {b, type_lo} != bmpx_pkg::TypeMagic)
               got = close_with(r, 8'h00, bmpx_pkg::ST_BAD_FILE);
            else if (p == bmpx_pkg::PosOffsetHi && offset < bmpx_pkg::MinOffset)
               got = close_with(r, 8'h00, bmpx_pkg::ST_BAD_FILE);
            else if (p >= bmpx_pkg::MinOffset && p == offset) begin
               ph = bmpx_pkg::PH_PIXELS;
               if (usable_bytes() == 0 || height == 0)
                  got = close_with(r, 8'h00, bmpx_pkg::ST_EXHAUSTED);
            end
         end
         if (ph == bmpx_pkg::PH_PIXELS && !got) begin
            use_n = usable_bytes();
            if (col < use_n) begin
               spent = (col + 1 == use_n) && (rows + 1 >= height);
               if (len_bits < bmpx_pkg::LenBits) begin
                  len_val |= 32'(b[0]) << len_bits;
                  len_bits++;
                  if (len_bits == bmpx_pkg::LenBits &&
                      (len_val == 0 || len_val[31] || len_val > 32'(max_len)))
                     got = close_with(r, 8'h00, bmpx_pkg::ST_BAD_LENGTH);
                  else if (spent)
                     got = close_with(r, 8'h00, bmpx_pkg::ST_EXHAUSTED);
               end else begin
                  val = char_acc | (8'(b[0]) << char_idx);
                  char_idx++;
                  if (char_idx == 8) begin
                     char_acc = 0;
                     char_idx = 0;
                     chars_done++;
                     if (chars_done == len_val)
                        got = close_with(r, val, bmpx_pkg::ST_DATA);
                     else if (spent)
                        got = close_with(r, val, bmpx_pkg::ST_EXHAUSTED);
                     else begin
                        r.msg = val;
                        r.last = 1'b0;
                        r.st = bmpx_pkg::ST_DATA;
                        got = 1'b1;
                     end
                  end else begin
                     char_acc = val;
                     if (spent) got = close_with(r, val, bmpx_pkg::ST_EXHAUSTED);
                  end
               end
            end
            col++;
            if (col >= pitch) begin
               col = 0;
               rows++;
            end
         end
         if (eof) begin
            if (!got && ph != bmpx_pkg::PH_DONE) begin
               if (ph == bmpx_pkg::PH_HEADER && p < bmpx_pkg::PosBppHi)
                  got = close_with(r, 8'h00, bmpx_pkg::ST_BAD_FILE);
               else if (ph == bmpx_pkg::PH_HEADER || len_bits < bmpx_pkg::LenBits)
                  got = close_with(r, 8'h00, bmpx_pkg::ST_EXHAUSTED);
               else
                  got = close_with(r, char_acc, bmpx_pkg::ST_EXHAUSTED);
            end else if (got && !r.last) begin
               // file ends on a byte that is not the final one
               r.last = 1'b1;
               r.st = bmpx_pkg::ST_EXHAUSTED;
            end
            clear_walk();
         end else begin
            pos = p + 1;
         end
         if (got) expected_chars.push_back(r);
      endfunction

      task note_mismatch(string what);
         mismatches++;
         $display("mismatch: %s", what);
      endtask

      task check_output(logic [7:0] m, logic l, logic [1:0] s);
         recovered_type w;
         results_seen++;
         if (expected_chars.size() == 0) begin
            note_mismatch($sformatf("result %0d not expected: byte %02h last %0b code %0d",
                                    results_seen, m, l, s));
            return;
         end
         w = expected_chars.pop_front();
         if (m !== w.msg)
            note_mismatch($sformatf("result %0d rsp_message_byte got %02h want %02h",
                                    results_seen, m, w.msg));
         if (l !== w.last)
            note_mismatch($sformatf("result %0d rsp_last_byte got %0b want %0b",
                                    results_seen, l, w.last));
         if (s !== w.st)
            note_mismatch($sformatf("result %0d rsp_status got %0d want %0d",
                                    results_seen, s, w.st));
      endtask

      task flush_leftovers();
         recovered_type w;
         while (expected_chars.size() > 0) begin
            w = expected_chars.pop_front();
            note_mismatch($sformatf("result never came: byte %02h last %0b code %0d",
                                    w.msg, w.last, w.st));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_file_byte;
   logic        req_end_of_file;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_message_byte;
   logic        rsp_last_byte;
   logic [1:0]  rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic [30:0] csr_max_message_length;

   message_scoreboard sb = new();
   bit [7:0]  file_bytes[$];
   bit [30:0] cur_limit = bmpx_pkg::MaxLenReset;
   int        rsp_taken = 0;
   int        hold_left = 0;
   bit        rsp_calm = 1'b0;

   bmp_lsb_message_extractor i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_file_byte          (req_file_byte),
      .req_end_of_file        (req_end_of_file),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_message_byte       (rsp_message_byte),
      .rsp_last_byte          (rsp_last_byte),
      .rsp_status             (rsp_status),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_max_message_length (csr_max_message_length)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // handshakes are sampled here, before the block updates its registers
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_output(rsp_message_byte, rsp_last_byte, rsp_status);
            rsp_taken++;
            if (rsp_taken % 16 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
            // one long hold-off so the block backs up into its input
            if (rsp_taken == 25) hold_left = 400;
            else hold_left = rsp_calm ? 0 : $urandom_range(0, 11);
         end
         if (req_valid && !req_stall) sb.take_file_byte(req_file_byte, req_end_of_file);
         if (csr_valid && csr_ready) sb.set_limit(csr_max_message_length);
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // entered and left at a falling edge; valid stays up for a following item
   task automatic send_byte(input bit [7:0] b, input bit eof, input bit calm);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_file_byte <= b;
      req_end_of_file <= eof;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_file();
      bit calm;
      calm = ($urandom_range(0, 3) == 0);
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1, calm);
   endtask

   task automatic wait_drained();
      int spins;
      spins = 0;
      req_valid <= 1'b0;
      while (sb.expected_chars.size() != 0 && spins < 20000) begin
         @(posedge clock);
         spins++;
      end
      // a trailing item with no result may still be in the pipeline
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_limit(input bit [30:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_max_message_length <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_limit = v;
   endtask

   task automatic put_le(input bit [31:0] v, input int at, input int n);
      for (int i = 0; i < n; i++) file_bytes[at + i] = v[8 * i +: 8];
   endtask

   // one bitmap carrying a hidden message, sometimes with a flaw in it
   task automatic make_bitmap();
      int        flaw;
      int        msg_len;
      int        nbits;
      int        extra;
      int        cut;
      bit [15:0] magic;
      bit [15:0] bpp_v;
      bit [31:0] offs;
      bit [31:0] wid;
      bit [31:0] hgt;
      bit [31:0] hgt_mag;
      bit [31:0] len_field;
      bit [63:0] use_n;
      bit [63:0] pch;
      bit [63:0] rows_needed;
      bit [63:0] gen_rows;
      bit [7:0]  px;
      bit        stream[$];
      file_bytes.delete();
      flaw = ($urandom_range(0, 99) < 35) ? $urandom_range(1, 10) : 0;
      magic = bmpx_pkg::TypeMagic;
      offs = ($urandom_range(0, 3) == 0) ? 32'd54 : 32'($urandom_range(30, 34));
      wid = (flaw == 7) ? 32'd1 : 32'($urandom_range(1, 8));
      case ($urandom_range(0, 7))
         0: bpp_v = 16'd32;
         1: bpp_v = 16'd8;
         2: bpp_v = 16'd1;
         3: bpp_v = 16'($urandom_range(0, 64));
         default: bpp_v = 16'd24;
      endcase
      msg_len = $urandom_range(1, (cur_limit < 6) ? int'(cur_limit) : 6);
      len_field = 32'(msg_len);
      nbits = 32 + 8 * msg_len;
      case (flaw)
         1: magic ^= 16'(1) << $urandom_range(0, 15);
         2: offs = 32'($urandom_range(0, 29));
         3: wid = $urandom_range(0, 1) ? 32'd0 : ($urandom | 32'h8000_0000);
         6: offs = $urandom | 32'h100;
         8: begin
            case ($urandom_range(0, 3))
               0: len_field = 0;
               1: len_field = $urandom | 32'h8000_0000;
               2: len_field = 32'(cur_limit) + 1;
               default: len_field = $urandom;
            endcase
         end
         default: ;
      endcase
      use_n = (wid == 0 || wid[31]) ? 64'd0 : 64'(wid) * 3;
      rows_needed = (use_n == 0) ? 64'd0 : (nbits + use_n - 1) / use_n;
      hgt = 32'(rows_needed) + 32'($urandom_range(0, 1));
      if (flaw == 4) hgt = 0;
      if (flaw == 5) hgt = 32'h8000_0000;
      if (flaw == 7) hgt = 32'($urandom_range(1, 32'(rows_needed - 1)));
      if (flaw != 5 && $urandom_range(0, 2) == 0) hgt = -hgt;
      hgt_mag = hgt[31] ? -hgt : hgt;

      for (int k = 0; k < 30; k++) file_bytes.push_back(8'($urandom));
      file_bytes[bmpx_pkg::PosTypeLo] = magic[7:0];
      file_bytes[bmpx_pkg::PosTypeHi] = magic[15:8];
      put_le(offs, bmpx_pkg::PosOffsetLo, 4);
      put_le(wid, bmpx_pkg::PosWidthLo, 4);
      put_le(hgt, bmpx_pkg::PosHeightLo, 4);
      put_le(32'(bpp_v), bmpx_pkg::PosBppLo, 2);
      for (int k = 30; k < offs && k < 90; k++) file_bytes.push_back(8'($urandom));

      for (int k = 0; k < 32; k++) stream.push_back(len_field[k]);
      repeat (msg_len) begin
         px = 8'($urandom);
         for (int k = 0; k < 8; k++) stream.push_back(px[k]);
      end
      pch = (((64'(bpp_v) * (use_n / 3)) + 64'd31) >> 5) << 2;
      if (pch < use_n) pch = use_n;
      gen_rows = (64'(hgt_mag) < rows_needed) ? 64'(hgt_mag) : rows_needed;
      for (longint r = 0; r < gen_rows; r++) begin
         for (longint c = 0; c < pch; c++) begin
            px = 8'($urandom);
            if (c < use_n && stream.size() > 0) px[0] = stream.pop_front();
            file_bytes.push_back(px);
         end
      end
      extra = $urandom_range((gen_rows == 0) ? 1 : 0, 3);
      repeat (extra) file_bytes.push_back(8'($urandom));

      if (flaw == 9) cut = $urandom_range(2, file_bytes.size());
      else if (flaw == 10) cut = $urandom_range(2, 29);
      else cut = file_bytes.size();
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
   endtask

   initial begin
      bit [30:0] limits[4];
      reset = 1'b1;
      req_valid = 1'b0;
      req_file_byte = 8'h00;
      req_end_of_file = 1'b0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_max_message_length = '0;
      limits[0] = bmpx_pkg::MaxLenReset;
      limits[1] = 31'd1;
      limits[2] = 31'h7FFF_FFFF;
      limits[3] = 31'($urandom_range(2, 6));
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // wrong type bytes
      file_bytes = '{8'hFF, 8'h00, 8'hFF};
      send_file();
      // file ends inside the header
      file_bytes = '{bmpx_pkg::TypeMagic[7:0], bmpx_pkg::TypeMagic[15:8],
                     8'hFF, 8'h00, 8'h80};
      send_file();
      // pixel offset under the header size
      file_bytes = '{bmpx_pkg::TypeMagic[7:0], bmpx_pkg::TypeMagic[15:8], 8'h00, 8'hFF,
                     8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'd29, 8'h00, 8'h00,
                     8'h00, 8'hFF};
      send_file();

      for (int p = 0; p < 4; p++) begin
         if (p > 0) write_limit(limits[p]);
         while (sb.live_bytes < 23 + 400 * (p + 1)) begin
            make_bitmap();
            send_file();
         end
      end

      wait_drained();
      sb.flush_leftovers();
      if (sb.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
